FILE: design/pnm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PGM/PPM stream parser.
// No dependencies; every other design file imports this package.
package pnm_pkg;

    // One byte of the incoming file with its framing marks.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic       file_end;
    } item_t;

    // One parser result: a pixel, a completed header or an error.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] max_value;
        logic [2:0]  error_code;
    } result_t;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ERR_BAD_NUMBER = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd5;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    function automatic result_t error_result(input logic [2:0] code);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

FILE: design/pnm_parser.sv
`timescale 1ns / 1ps
// Parser state and the per-byte update logic that yields up to two results.
// Depends on pnm_pkg.
module pnm_parser
    import pnm_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  item_t       item,
    output result_t     res0,
    output result_t     res1,
    output logic [1:0]  res_cnt
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_TYPE,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_EOL,
        PH_DATA,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         fmt_reg, fmt_next;
    logic               comment_reg, comment_next;
    logic               token_reg, token_next;
    logic [15:0]        acc_reg, acc_next;
    logic [1:0]         chan_reg, chan_next;
    logic [15:0]        held_red_reg, held_red_next;
    logic [15:0]        held_green_reg, held_green_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [15:0]        maxval_reg, maxval_next;

    logic [7:0]         c;
    logic               is_digit;
    logic               is_space;
    logic [15:0]        acc_step;
    logic [19:0]        acc_wide;
    result_t            res_q [2];
    logic [1:0]         cnt;
    logic               main_err;
    logic [2:0]         main_code;
    logic               main_hdr;
    logic               take;
    logic [15:0]        take_val;
    logic [15:0]        hv;
    logic [DIM_W:0]     row_inc;
    logic [DIM_W:0]     col_inc;
    logic               last;
    logic [15:0]        rr;
    logic [15:0]        gg;

    assign c        = item.data_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    // Multiply by ten with shifts, add the digit, clamp to 16 bits.
    // A file start clears the accumulator before this byte is taken.
    always_comb
    begin
        acc_wide = ({4'b0, (item.file_start ? 16'd0 : acc_reg)} << 3)
                 + ({4'b0, (item.file_start ? 16'd0 : acc_reg)} << 1)
                 + 20'(c - CH_ZERO);
        acc_step = (acc_wide > 20'd65535) ? 16'hFFFF : acc_wide[15:0];
    end

    always_comb
    begin
        phase_next      = phase_reg;
        fmt_next        = fmt_reg;
        comment_next    = comment_reg;
        token_next      = token_reg;
        acc_next        = acc_reg;
        chan_next       = chan_reg;
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        res_q[0]        = '0;
        res_q[1]        = '0;
        cnt             = '0;
        main_err        = 1'b0;
        main_code       = ERR_NONE;
        main_hdr        = 1'b0;
        take            = 1'b0;
        take_val        = '0;
        hv              = '0;
        row_inc         = '0;
        col_inc         = '0;
        last            = 1'b0;
        rr              = '0;
        gg              = '0;

        if (item.file_start)
        begin
            phase_next      = PH_MAGIC;
            fmt_next        = '0;
            comment_next    = 1'b0;
            token_next      = 1'b0;
            acc_next        = '0;
            chan_next       = '0;
            held_red_next   = '0;
            held_green_next = '0;
            row_next        = '0;
            col_next        = '0;
            width_next      = '0;
            height_next     = '0;
            maxval_next     = '0;
        end

        unique case (phase_next)
            PH_MAGIC:
            begin
                if (c == CH_P)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    main_err  = 1'b1;
                    main_code = ERR_NO_MAGIC;
                end
            end
            PH_TYPE:
            begin
                if (c == CH_2 || c == CH_3 || c == CH_5 || c == CH_6)
                begin
                    // Bit 0 marks color, bit 1 marks binary samples.
                    fmt_next     = {(c == CH_5 || c == CH_6), (c == CH_3 || c == CH_6)};
                    phase_next   = PH_WIDTH;
                    token_next   = 1'b0;
                    acc_next     = '0;
                    comment_next = 1'b0;
                end
                else
                begin
                    main_err  = 1'b1;
                    main_code = ERR_BAD_TYPE;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                if (comment_next)
                begin
                    if (c == CH_LF)
                    begin
                        comment_next = 1'b0;
                    end
                end
                else if (is_digit)
                begin
                    acc_next   = acc_step;
                    token_next = 1'b1;
                end
                else if (is_space || c == CH_HASH)
                begin
                    if (token_next)
                    begin
                        hv         = acc_next;
                        token_next = 1'b0;
                        acc_next   = '0;
                        if (hv == 16'd0)
                        begin
                            main_err  = 1'b1;
                            main_code = ERR_BAD_NUMBER;
                        end
                        else if (phase_next == PH_WIDTH || phase_next == PH_HEIGHT)
                        begin
                            if ({1'b0, hv} > 17'(MAX_DIM))
                            begin
                                main_err  = 1'b1;
                                main_code = ERR_TOO_LARGE;
                            end
                            else if (phase_next == PH_WIDTH)
                            begin
                                width_next = DIM_W'(hv);
                                phase_next = PH_HEIGHT;
                            end
                            else
                            begin
                                height_next = DIM_W'(hv);
                                phase_next  = PH_MAXVAL;
                            end
                        end
                        else
                        begin
                            maxval_next = hv;
                            if (c == CH_LF)
                            begin
                                main_hdr = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_EOL;
                            end
                        end
                    end
                    if (!main_err && c == CH_HASH && (phase_next == PH_WIDTH
                        || phase_next == PH_HEIGHT || phase_next == PH_MAXVAL))
                    begin
                        comment_next = 1'b1;
                    end
                end
                else
                begin
                    main_err  = 1'b1;
                    main_code = ERR_BAD_NUMBER;
                end
            end
            PH_EOL:
            begin
                if (c == CH_LF)
                begin
                    main_hdr = 1'b1;
                end
            end
            PH_DATA:
            begin
                if (fmt_next[1])
                begin
                    take     = 1'b1;
                    take_val = {8'b0, c};
                end
                else if (is_digit)
                begin
                    acc_next   = acc_step;
                    token_next = 1'b1;
                end
                else if (is_space)
                begin
                    if (token_next)
                    begin
                        take       = 1'b1;
                        take_val   = acc_next;
                        token_next = 1'b0;
                        acc_next   = '0;
                    end
                end
                else
                begin
                    main_err  = 1'b1;
                    main_code = ERR_BAD_NUMBER;
                end
            end
            default:
            begin
            end
        endcase

        if (main_err)
        begin
            res_q[cnt[0]] = error_result(main_code);
            cnt           = cnt + 2'd1;
            phase_next    = PH_ERROR;
            token_next    = 1'b0;
            comment_next  = 1'b0;
        end

        if (main_hdr)
        begin
            res_q[cnt[0]]              = '0;
            res_q[cnt[0]].kind         = KIND_HEADER;
            res_q[cnt[0]].image_width  = 13'(width_next);
            res_q[cnt[0]].image_height = 13'(height_next);
            res_q[cnt[0]].max_value    = maxval_next;
            cnt                        = cnt + 2'd1;
            phase_next                 = PH_DATA;
            row_next                   = '0;
            col_next                   = '0;
            chan_next                  = '0;
            token_next                 = 1'b0;
            acc_next                   = '0;
        end

        // End of file closes a pending ASCII token. This never coincides with a
        // sample taken above, so one sample path serves both cases.
        if (item.file_end && phase_next == PH_DATA && !fmt_next[1] && token_next)
        begin
            take       = 1'b1;
            take_val   = acc_next;
            token_next = 1'b0;
            acc_next   = '0;
        end

        if (take)
        begin
            if (fmt_next[0] && chan_next == 2'd0)
            begin
                held_red_next = take_val;
                chan_next     = 2'd1;
            end
            else if (fmt_next[0] && chan_next == 2'd1)
            begin
                held_green_next = take_val;
                chan_next       = 2'd2;
            end
            else
            begin
                rr        = fmt_next[0] ? held_red_next : take_val;
                gg        = fmt_next[0] ? held_green_next : take_val;
                chan_next = 2'd0;
                row_inc   = {1'b0, row_next} + 1'b1;
                col_inc   = {1'b0, col_next} + 1'b1;
                last      = (row_inc == {1'b0, height_next}) && (col_inc == {1'b0, width_next});
                res_q[cnt[0]]              = '0;
                res_q[cnt[0]].kind         = KIND_PIXEL;
                res_q[cnt[0]].red          = rr;
                res_q[cnt[0]].green        = gg;
                res_q[cnt[0]].blue         = take_val;
                res_q[cnt[0]].pixel_row    = 12'(row_next);
                res_q[cnt[0]].pixel_column = 12'(col_next);
                res_q[cnt[0]].last_pixel   = last;
                cnt                        = cnt + 2'd1;
                if (last)
                begin
                    phase_next = PH_DONE;
                end
                else if (col_inc >= {1'b0, width_next})
                begin
                    col_next = '0;
                    row_next = row_inc[DIM_W-1:0];
                end
                else
                begin
                    col_next = col_inc[DIM_W-1:0];
                end
            end
        end

        if (item.file_end && phase_next != PH_DONE && phase_next != PH_ERROR)
        begin
            res_q[cnt[0]] = error_result(ERR_TRUNCATED);
            cnt           = cnt + 2'd1;
            phase_next    = PH_ERROR;
            token_next    = 1'b0;
            comment_next  = 1'b0;
        end
    end

    assign res0    = res_q[0];
    assign res1    = res_q[1];
    assign res_cnt = step_en ? cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            fmt_reg        <= '0;
            comment_reg    <= 1'b0;
            token_reg      <= 1'b0;
            acc_reg        <= '0;
            chan_reg       <= '0;
            held_red_reg   <= '0;
            held_green_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            fmt_reg        <= fmt_next;
            comment_reg    <= comment_next;
            token_reg      <= token_next;
            acc_reg        <= acc_next;
            chan_reg       <= chan_next;
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            maxval_reg     <= maxval_next;
        end
    end

endmodule

FILE: design/pnm_result_fifo.sv
`timescale 1ns / 1ps
// Small result queue that takes up to two results per cycle and hands out one while pop is high.
// Depends on pnm_pkg.
module pnm_result_fifo
    import pnm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       out_valid,
    output result_t    out_data,
    input  logic       pop
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    result_t        mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic [AW-1:0]  wr_ptr_inc;
    logic           pop_fire;

    assign out_valid   = (count_reg != '0);
    assign out_data    = mem[rd_ptr_reg];
    assign pop_fire    = pop && out_valid;
    // Room for a worst-case byte that yields two results.
    assign room        = (count_reg <= (AW + 1)'(DEPTH - 2));
    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop_fire);
    assign count_next  = count_reg + (AW + 1)'(push_cnt) - (AW + 1)'(pop_fire);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_inc] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/pnm_image_stream_parser_core.sv
`timescale 1ns / 1ps
// Top level of the PGM/PPM byte-stream parser: input register, parser, result queue.
// Depends on pnm_pkg, pnm_parser and pnm_result_fifo.
//
//   Channel   Valid          Stall          Payload
//   bytes     byte_valid     byte_stall     byte_data   (item_t)
//   results   result_valid   result_stall   result_data (result_t)
//
// One byte is taken per cycle while byte_stall is low. A byte is registered on transfer
// and decoded from the input register once the queue has room; its results go into the queue.
// A byte that yields two results hands them out one after the other; the input stalls only
// while the four-entry result queue holds more than two results.
// Reset clears the parser state, the input valid flag and the queue.
module pnm_image_stream_parser_core
    import pnm_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    output logic    byte_stall,
    input  item_t   byte_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       room;
    logic       advance;
    result_t    res0;
    result_t    res1;
    logic [1:0] res_cnt;

    assign advance    = in_valid_reg && room;
    assign byte_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_data;
        end
    end

    pnm_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    pnm_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (result_valid),
        .out_data  (result_data),
        .pop       (!result_stall)
    );

endmodule

FILE: design/pnm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the parser top level, attached by the bind at the end.
// Depends on pnm_pkg and pnm_image_stream_parser_core.
module pnm_checker
    import pnm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    byte_valid,
    input logic    byte_stall,
    input item_t   byte_data,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_data
);

    // In the cycle after reset is seen asserted, nothing is offered and nothing is held back.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid && !byte_stall)
        else $error("outputs active during reset");

    // A stalled byte transfer keeps its payload.
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
        else $error("stalled byte changed");

    // A stalled result transfer keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // An error result carries a code, a zero red value and width, and no last-pixel mark.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == KIND_ERROR |->
            result_data.error_code != ERR_NONE && result_data.red == 16'd0
            && result_data.image_width == 13'd0 && !result_data.last_pixel)
        else $error("malformed error result");

    // A pixel or header result never carries an error code.
    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == KIND_PIXEL || result_data.kind == KIND_HEADER)
            |-> result_data.error_code == ERR_NONE)
        else $error("error code on non-error result");

endmodule

bind pnm_image_stream_parser_core pnm_checker u_pnm_checker (.*);

FILE: tb/sv/pnm_image_stream_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PGM/PPM byte-stream parser core: a short directed
// script, then random well-formed and broken files checked against a byte-level predictor.
// Depends on pnm_pkg and pnm_image_stream_parser_core.
module pnm_image_stream_parser_core_tb;
    import pnm_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_DIM      = 4096;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_SAMPLES  = 48;

    // Bit 0 of the format marks color, bit 1 marks binary samples.
    localparam logic [1:0] FMT_P2 = 2'd0;
    localparam logic [1:0] FMT_P3 = 2'd1;
    localparam logic [1:0] FMT_P5 = 2'd2;
    localparam logic [1:0] FMT_P6 = 2'd3;

    typedef enum logic [3:0] {
        SEEK_MAGIC,
        SEEK_TYPE,
        READ_WIDTH,
        READ_HEIGHT,
        READ_MAXVAL,
        SKIP_LINE,
        READ_SAMPLES,
        IMAGE_DONE,
        HALTED
    } parser_phase_t;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } script_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    byte_valid   = 1'b0;
    logic    byte_stall;
    item_t   byte_data    = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_data;

    // Predictor state.
    parser_phase_t phase;
    logic [1:0]    fmt;
    bit            in_remark;
    bit            token_open;
    logic [15:0]   acc;
    logic [1:0]    chan;
    logic [15:0]   red_hold;
    logic [15:0]   green_hold;
    logic [11:0]   row_idx;
    logic [11:0]   col_idx;
    logic [12:0]   width_q;
    logic [12:0]   height_q;
    logic [15:0]   maxval_q;

    result_t     byte_results[$];
    result_t     pending_results[$];
    logic [7:0]  file_bytes[$];
    script_row_t script[$];

    int bytes_sent   = 0;
    int results_seen = 0;
    int fail_count   = 0;
    bit sender_steady = 1'b0;

    pnm_image_stream_parser_core #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic reset_predictor();
        phase      = SEEK_MAGIC;
        fmt        = FMT_P2;
        in_remark  = 1'b0;
        token_open = 1'b0;
        acc        = '0;
        chan       = '0;
        red_hold   = '0;
        green_hold = '0;
        row_idx    = '0;
        col_idx    = '0;
        width_q    = '0;
        height_q   = '0;
        maxval_q   = '0;
    endtask

    task automatic flag_error(logic [2:0] code);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        byte_results.push_back(r);
        phase      = HALTED;
        token_open = 1'b0;
        in_remark  = 1'b0;
    endtask

    task automatic add_digit(logic [7:0] c);
        int unsigned v;
        v          = 32'(acc) * 10 + 32'(c - CH_ZERO);
        acc        = (v > 65535) ? 16'hFFFF : v[15:0];
        token_open = 1'b1;
    endtask

    task automatic open_image();
        result_t r;
        r              = '0;
        r.kind         = KIND_HEADER;
        r.image_width  = width_q;
        r.image_height = height_q;
        r.max_value    = maxval_q;
        byte_results.push_back(r);
        phase      = READ_SAMPLES;
        row_idx    = '0;
        col_idx    = '0;
        chan       = '0;
        token_open = 1'b0;
        acc        = '0;
    endtask

    task automatic place_sample(logic [15:0] v);
        result_t r;
        bit      last;
        // Color samples are held until the blue one completes the pixel.
        if (fmt[0] && chan == 2'd0)
        begin
            red_hold = v;
            chan     = 2'd1;
            return;
        end
        if (fmt[0] && chan == 2'd1)
        begin
            green_hold = v;
            chan       = 2'd2;
            return;
        end
        chan = 2'd0;
        last = (int'(row_idx) + 1 == int'(height_q)) && (int'(col_idx) + 1 == int'(width_q));
        r              = '0;
        r.kind         = KIND_PIXEL;
        r.red          = fmt[0] ? red_hold : v;
        r.green        = fmt[0] ? green_hold : v;
        r.blue         = v;
        r.pixel_row    = row_idx;
        r.pixel_column = col_idx;
        r.last_pixel   = last;
        byte_results.push_back(r);
        if (last)
        begin
            phase = IMAGE_DONE;
        end
        else if (int'(col_idx) + 1 >= int'(width_q))
        begin
            col_idx = '0;
            row_idx = row_idx + 1'b1;
        end
        else
        begin
            col_idx = col_idx + 1'b1;
        end
    endtask

    task automatic close_header_value(logic [7:0] c);
        logic [15:0] v;
        v          = acc;
        token_open = 1'b0;
        acc        = '0;
        if (v == 0)
        begin
            flag_error(ERR_BAD_NUMBER);
            return;
        end
        if (phase == READ_WIDTH || phase == READ_HEIGHT)
        begin
            if (v > MAX_DIM)
            begin
                flag_error(ERR_TOO_LARGE);
                return;
            end
            if (phase == READ_WIDTH)
            begin
                width_q = v[12:0];
                phase   = READ_HEIGHT;
            end
            else
            begin
                height_q = v[12:0];
                phase    = READ_MAXVAL;
            end
            return;
        end
        maxval_q = v;
        if (c == CH_LF)
            open_image();
        else
            phase = SKIP_LINE;
    endtask

    task automatic header_char(logic [7:0] c);
        if (in_remark)
        begin
            if (c == CH_LF)
                in_remark = 1'b0;
            return;
        end
        if (is_digit(c))
        begin
            add_digit(c);
            return;
        end
        if (is_blank(c) || c == CH_HASH)
        begin
            if (token_open)
                close_header_value(c);
            if (c == CH_HASH && (phase == READ_WIDTH || phase == READ_HEIGHT
                                 || phase == READ_MAXVAL))
                in_remark = 1'b1;
            return;
        end
        flag_error(ERR_BAD_NUMBER);
    endtask

    // Works out the results that one accepted byte causes, in order, into byte_results.
    task automatic decode_byte(item_t it);
        logic [7:0]  c;
        logic [15:0] v;
        c = it.data_byte;
        byte_results.delete();
        if (it.file_start)
            reset_predictor();
        case (phase)
            SEEK_MAGIC:
            begin
                if (c == CH_P)
                    phase = SEEK_TYPE;
                else
                    flag_error(ERR_NO_MAGIC);
            end
            SEEK_TYPE:
            begin
                case (c)
                    CH_2:    fmt = FMT_P2;
                    CH_3:    fmt = FMT_P3;
                    CH_5:    fmt = FMT_P5;
                    CH_6:    fmt = FMT_P6;
                    default: flag_error(ERR_BAD_TYPE);
                endcase
                if (phase == SEEK_TYPE)
                begin
                    phase      = READ_WIDTH;
                    token_open = 1'b0;
                    acc        = '0;
                    in_remark  = 1'b0;
                end
            end
            READ_WIDTH, READ_HEIGHT, READ_MAXVAL: header_char(c);
            SKIP_LINE:
            begin
                if (c == CH_LF)
                    open_image();
            end
            READ_SAMPLES:
            begin
                if (fmt[1])
                begin
                    place_sample({8'h00, c});
                end
                else if (is_digit(c))
                begin
                    add_digit(c);
                end
                else if (is_blank(c))
                begin
                    if (token_open)
                    begin
                        v          = acc;
                        token_open = 1'b0;
                        acc        = '0;
                        place_sample(v);
                    end
                end
                else
                begin
                    flag_error(ERR_BAD_NUMBER);
                end
            end
            default: ;
        endcase
        if (it.file_end && phase != IMAGE_DONE && phase != HALTED)
        begin
            if (phase == READ_SAMPLES && !fmt[1] && token_open)
            begin
                v          = acc;
                token_open = 1'b0;
                acc        = '0;
                place_sample(v);
            end
            if (phase != IMAGE_DONE)
                flag_error(ERR_TRUNCATED);
        end
    endtask

    function automatic int idle_len(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF);
        return b;
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82)
            return $urandom_range(1, 4);
        if (r < 91)
            return $urandom_range(5, 16);
        if (r < 94)
            return $urandom_range(17, MAX_DIM);
        if (r < 96)
            return MAX_DIM;
        if (r < 98)
            return $urandom_range(MAX_DIM + 1, 99999);
        return 0;
    endfunction

    function automatic int pick_maxval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(1, 255);
        if (r < 75)
            return $urandom_range(1, 65535);
        if (r < 88)
            return 65535;
        if (r < 96)
            return $urandom_range(65536, 999999);
        return 0;
    endfunction

    function automatic int pick_sample(int maxval);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, (maxval > 65535) ? 65535 : maxval);
        if (r < 95)
            return $urandom_range(0, 65535);
        return $urandom_range(65536, 9999999);
    endfunction

    task automatic push_number(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            file_bytes.push_back(CH_ZERO);
        foreach (s[i])
            file_bytes.push_back(s[i]);
    endtask

    task automatic push_blanks(int least);
        repeat ($urandom_range(least, 2))
            file_bytes.push_back(blank_char());
    endtask

    // Separator inside the header: whitespace (possibly none), sometimes followed by a comment line.
    task automatic push_gap(bit may_be_empty);
        push_blanks(may_be_empty ? 0 : 1);
        if ($urandom_range(0, 4) == 0)
        begin
            file_bytes.push_back(CH_HASH);
            repeat ($urandom_range(0, 4))
                file_bytes.push_back(any_but_lf());
            file_bytes.push_back(CH_LF);
        end
    endtask

    // Builds one file into file_bytes; most are well formed, the rest broken on purpose.
    task automatic compose_file(output bit end_marked);
        logic [7:0] type_ch;
        bit         color;
        bit         binary;
        int         w;
        int         h;
        int         maxval;
        int         samples;
        int         r;
        int         keep;
        longint     total;
        file_bytes.delete();
        end_marked = 1'b1;
        if ($urandom_range(0, 99) < 6)
        begin
            repeat ($urandom_range(2, 6))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                file_bytes[0] = CH_P;
            return;
        end
        case ($urandom_range(0, 3))
            0:       type_ch = CH_2;
            1:       type_ch = CH_3;
            2:       type_ch = CH_5;
            default: type_ch = CH_6;
        endcase
        color  = (type_ch == CH_3 || type_ch == CH_6);
        binary = (type_ch == CH_5 || type_ch == CH_6);
        w      = pick_dim();
        h      = (w > 4) ? $urandom_range(1, 2) : pick_dim();
        maxval = pick_maxval();
        file_bytes.push_back(CH_P);
        file_bytes.push_back(type_ch);
        push_gap(1'b1);
        push_number(w);
        push_gap(1'b0);
        push_number(h);
        push_gap(1'b0);
        push_number(maxval);
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            file_bytes.push_back(CH_LF);
        end
        else
        begin
            file_bytes.push_back((r < 80) ? ($urandom_range(0, 1) ? CH_SPACE : CH_CR) : CH_HASH);
            repeat ($urandom_range(0, 3))
                file_bytes.push_back(any_but_lf());
            file_bytes.push_back(CH_LF);
        end
        // Large images are cut short, which ends them with a truncation error.
        total   = longint'(w) * longint'(h) * (color ? 3 : 1);
        samples = (total > MAX_SAMPLES) ? MAX_SAMPLES : int'(total);
        for (int k = 0; k < samples; k++)
        begin
            if (binary)
            begin
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                push_number(pick_sample(maxval));
                if (k < samples - 1 || $urandom_range(0, 1))
                    push_blanks(1);
            end
        end
        r = $urandom_range(0, 99);
        if (r >= 70 && r < 84)
        begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
            end_marked = (r < 78);
        end
        else if (r >= 84 && r < 92)
        begin
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (r >= 92)
        begin
            repeat ($urandom_range(1, 3))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Offers one byte, waits for its transfer and records what it should produce.
    task automatic send_item(item_t it, bit typed, result_t want);
        int gap;
        gap = idle_len(sender_steady);
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data  <= it;
        do
            @(posedge clk);
        while (byte_stall);
        bytes_sent++;
        decode_byte(it);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (byte_results[i])
                pending_results.push_back(byte_results[i]);
    endtask

    task automatic add_row(logic [7:0] c, bit fs, bit fe, bit typed = 1'b0,
                           result_t want = '0);
        script_row_t row;
        row.stim  = '{data_byte: c, file_start: fs, file_end: fe};
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    function automatic bit same_result(result_t a, result_t b);
        return a.kind === b.kind && a.red === b.red && a.green === b.green
            && a.blue === b.blue && a.pixel_row === b.pixel_row
            && a.pixel_column === b.pixel_column && a.last_pixel === b.last_pixel
            && a.image_width === b.image_width && a.image_height === b.image_height
            && a.max_value === b.max_value && a.error_code === b.error_code;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("kind=%0d rgb=%0d/%0d/%0d at=%0d,%0d last=%0b hdr=%0dx%0d max=%0d err=%0d",
                         r.kind, r.red, r.green, r.blue, r.pixel_row, r.pixel_column,
                         r.last_pixel, r.image_width, r.image_height, r.max_value,
                         r.error_code);
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    initial
    begin : result_monitor
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    note_failure($sformatf("result %0d with nothing expected: %s",
                                           results_seen, show(result_data)));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (!same_result(want, result_data))
                        note_failure($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                               results_seen, show(want), show(result_data)));
                end
                results_seen++;
            end
        end
    end

    // Receiver: random stalls, steady stretches, and one long hold-off to back up the block.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int tick;
        bit hold_done;
        bit steady;
        stall_left = 0;
        hold_left  = 0;
        tick       = 0;
        hold_done  = 1'b0;
        steady     = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 150 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (!hold_done && bytes_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_left = idle_len(steady);
                result_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("pnm_image_stream_parser_core regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        item_t it;
        bit    end_marked;
        reset_predictor();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        //      byte      start end  typed  expected result
        add_row("A",      1'b1, 1'b0, 1'b1, error_result(ERR_NO_MAGIC));
        add_row(CH_P,     1'b1, 1'b0);
        add_row("7",      1'b0, 1'b0, 1'b1, error_result(ERR_BAD_TYPE));
        // A zero width closed by a comment mark.
        add_row(CH_P,     1'b1, 1'b0);
        add_row(CH_5,     1'b0, 1'b0);
        add_row(CH_ZERO,  1'b0, 1'b0);
        add_row(CH_HASH,  1'b0, 1'b0, 1'b1, error_result(ERR_BAD_NUMBER));
        // Width one above the limit.
        add_row(CH_P,     1'b1, 1'b0);
        add_row(CH_6,     1'b0, 1'b0);
        add_row("4",      1'b0, 1'b0);
        add_row(CH_ZERO,  1'b0, 1'b0);
        add_row("9",      1'b0, 1'b0);
        add_row("7",      1'b0, 1'b0);
        add_row(CH_TAB,   1'b0, 1'b0, 1'b1, error_result(ERR_TOO_LARGE));
        // Stray character in the header.
        add_row(CH_P,     1'b1, 1'b0);
        add_row(CH_3,     1'b0, 1'b0);
        add_row("!",      1'b0, 1'b0, 1'b1, error_result(ERR_BAD_NUMBER));
        // 1x1 gray image: width right after the type, a comment, then one sample
        // closed only by the end-of-file mark, followed by a byte that is ignored.
        add_row(CH_P,     1'b1, 1'b0);
        add_row(CH_2,     1'b0, 1'b0);
        add_row("1",      1'b0, 1'b0);
        add_row(CH_HASH,  1'b0, 1'b0);
        add_row(8'h80,    1'b0, 1'b0);
        add_row(CH_LF,    1'b0, 1'b0);
        add_row("1",      1'b0, 1'b0);
        add_row(CH_SPACE, 1'b0, 1'b0);
        add_row("9",      1'b0, 1'b0);
        add_row(CH_LF,    1'b0, 1'b0, 1'b1,
                result_t'{kind: KIND_HEADER, image_width: 13'd1, image_height: 13'd1,
                          max_value: 16'd9, default: 0});
        add_row("8",      1'b0, 1'b1, 1'b1,
                result_t'{kind: KIND_PIXEL, red: 16'd8, green: 16'd8, blue: 16'd8,
                          last_pixel: 1'b1, default: 0});
        add_row(8'hFF,    1'b0, 1'b0);
        // File ends inside the header.
        add_row(CH_P,     1'b1, 1'b0);
        add_row(CH_3,     1'b0, 1'b0);
        add_row("1",      1'b0, 1'b1, 1'b1, error_result(ERR_TRUNCATED));

        foreach (script[i])
            send_item(script[i].stim, script[i].typed, script[i].want);

        while (bytes_sent < script.size() + RANDOM_ITEMS)
        begin
            sender_steady = ($urandom_range(0, 4) == 0);
            compose_file(end_marked);
            foreach (file_bytes[i])
            begin
                it.data_byte  = file_bytes[i];
                it.file_start = (i == 0);
                it.file_end   = end_marked && (i == file_bytes.size() - 1);
                send_item(it, 1'b0, '0);
            end
        end
        @(negedge clk);
        byte_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("pnm_image_stream_parser_core regression: pass");
        else
            $display("pnm_image_stream_parser_core regression: fail");
        $finish;
    end

endmodule
